[design/ctm_pkg.sv]
`default_nettype none

package ctm_pkg;

  localparam int SIDE_DEF      = 32;
  localparam int MAX_SLOTS_DEF = 4096;

  localparam int SIZE_W      = 6;
  localparam int POS_W       = 5;
  localparam int OP_W        = 3;
  localparam int KIND_W      = 3;
  localparam int HANDLE_W    = 32;
  localparam int COUNT_W     = 16;
  localparam int SLOT_OUT_W  = 12;
  localparam int SLOTS_OUT_W = 13;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;

  localparam int IN_X_LSB      = 0;
  localparam int IN_Y_LSB      = IN_X_LSB + POS_W;
  localparam int IN_Z_LSB      = IN_Y_LSB + POS_W;
  localparam int IN_HANDLE_LSB = IN_Z_LSB + POS_W;
  localparam int IN_KIND_LSB   = IN_HANDLE_LSB + HANDLE_W;
  localparam int IN_USED_W     = IN_KIND_LSB + KIND_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_USED_W  = KIND_W + SLOT_OUT_W + HANDLE_W + 4 * COUNT_W + 2 * SLOTS_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNDEF    = 3'd0,
    KIND_SOLID    = 3'd1,
    KIND_FLUID    = 3'd2,
    KIND_IFACE_CF = 3'd3,
    KIND_IFACE_FC = 3'd4,
    KIND_BC       = 3'd5
  } kind_t;

  typedef enum logic [OP_W-1:0] {
    OP_SET_BC   = 3'd0,
    OP_SOLID    = 3'd1,
    OP_FLUID    = 3'd2,
    OP_UNDEF    = 3'd3,
    OP_SET_KIND = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_SAME  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOK   = 2'd2,
    ST_HANDLE = 2'd3
  } state_t;

  typedef struct packed {
    logic  en;
    kind_t old_kind;
    kind_t new_kind;
  } cnt_upd_t;

endpackage

`default_nettype wire

[design/ctm_stats.sv]
`default_nettype none

module ctm_stats #(
  parameter int SIDE = ctm_pkg::SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ctm_pkg::SIZE_W-1:0]   size_x,
  input  logic [ctm_pkg::SIZE_W-1:0]   size_y,
  input  logic [ctm_pkg::SIZE_W-1:0]   size_z,
  input  ctm_pkg::cnt_upd_t            upd,
  output logic [ctm_pkg::COUNT_W-1:0]  solid_count,
  output logic [ctm_pkg::COUNT_W-1:0]  fluid_count,
  output logic [ctm_pkg::COUNT_W-1:0]  bc_count,
  output logic [ctm_pkg::COUNT_W-1:0]  undefined_count
);
  import ctm_pkg::*;

  localparam int CNT_W = $clog2(SIDE * SIDE * SIDE + 1);
  localparam int VOL_W = 3 * SIZE_W;
  localparam int UW    = (VOL_W > CNT_W) ? VOL_W : CNT_W;

  logic [2*SIZE_W-1:0] xy_r;
  logic [VOL_W-1:0]    vol_r;
  logic [CNT_W-1:0]    solid_r, solid_nxt;
  logic [CNT_W-1:0]    fluid_r, fluid_nxt;
  logic [CNT_W-1:0]    bc_r, bc_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [UW-1:0]       vol_ext, used_ext, undef;

  always_ff @(posedge clk) begin
    xy_r  <= size_x * size_y;
    vol_r <= xy_r * size_z;
  end

  always_comb begin
    solid_nxt = solid_r + CNT_W'(upd.en && upd.new_kind == KIND_SOLID)
                        - CNT_W'(upd.en && upd.old_kind == KIND_SOLID);
    fluid_nxt = fluid_r + CNT_W'(upd.en && upd.new_kind == KIND_FLUID)
                        - CNT_W'(upd.en && upd.old_kind == KIND_FLUID);
    bc_nxt    = bc_r + CNT_W'(upd.en && upd.new_kind == KIND_BC)
                     - CNT_W'(upd.en && upd.old_kind == KIND_BC);
    used_nxt  = used_r + CNT_W'(upd.en && upd.new_kind != KIND_UNDEF)
                       - CNT_W'(upd.en && upd.old_kind != KIND_UNDEF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_r <= '0;
      fluid_r <= '0;
      bc_r    <= '0;
      used_r  <= '0;
    end else begin
      solid_r <= solid_nxt;
      fluid_r <= fluid_nxt;
      bc_r    <= bc_nxt;
      used_r  <= used_nxt;
    end
  end

  always_comb begin
    vol_ext  = UW'(vol_r);
    used_ext = UW'(used_r);
    undef    = (vol_ext > used_ext) ? vol_ext - used_ext : '0;
  end

  assign solid_count     = COUNT_W'(solid_r);
  assign fluid_count     = COUNT_W'(fluid_r);
  assign bc_count        = COUNT_W'(bc_r);
  assign undefined_count = COUNT_W'(undef);

endmodule

`default_nettype wire

[design/cell_type_map_with_slot_allocator_core.sv]
`default_nettype none

// Map of cell kinds over a SIDE^3 grid with a pool of boundary-condition slots. After reset the
// block sweeps the cell memory to undefined, one cell per cycle; in_tready stays low until the
// sweep ends, while size writes are taken at any time. An item is first read from the cell
// memory and then updated, with a step in between to read the slot table when the cell holds a
// slot and the op compares or reports the stored handle, since the slot table is read only after
// the cell word has arrived. Freed slots are reused last in, first out before the slot table
// grows. A finished result waits in an output register while the next item is read in. The
// counts in out_tdata reflect the state after the item's own update.
module cell_type_map_with_slot_allocator_core #(
  parameter int SIDE      = ctm_pkg::SIDE_DEF,
  parameter int MAX_SLOTS = ctm_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pos_x, pos_y, pos_z, bc_handle, new_kind, zero fill
  input  logic [ctm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op
  input  logic [ctm_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cell_kind, slot_index, slot_handle, solid_count, fluid_count, bc_count,
  // undefined_count, slots_used, free_slots, zero fill
  output logic [ctm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status
  output logic [ctm_pkg::STATUS_W-1:0]     out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ctm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctm_pkg::SIZE_W-1:0]       cfg_data
);
  import ctm_pkg::*;

  localparam int AW       = $clog2(SIDE);
  localparam int ADDR_W   = 3 * AW;
  localparam int SW       = $clog2(MAX_SLOTS);
  localparam int SCW      = SW + 1;
  localparam int CELL_W   = KIND_W + SW;
  localparam int SIDE_CAP = (SIDE < 63) ? SIDE : 63;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SIDE_CAP);
  localparam logic [SCW-1:0]    MAX_CNT  = SCW'(MAX_SLOTS);

  logic [CELL_W-1:0]   cell_mem [(1 << ADDR_W)];
  logic [HANDLE_W-1:0] slot_mem [MAX_SLOTS];
  logic [SW-1:0]       free_mem [MAX_SLOTS];

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic [SIZE_W-1:0]   size_x_r, size_y_r, size_z_r;
  logic [OP_W-1:0]     op_r;
  logic [POS_W-1:0]    pos_x_r, pos_y_r, pos_z_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [KIND_W-1:0]   nk_r;
  logic [CELL_W-1:0]   cell_rd_r;
  logic [HANDLE_W-1:0] slot_rd_r;
  logic [SW-1:0]       free_rd_r;
  logic [SCW-1:0]      free_top_r, free_top_nxt;
  logic [SCW-1:0]      slot_len_r, slot_len_nxt;
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  kind_t               okind_r, okind_nxt;
  logic [SW-1:0]       oslot_r, oslot_nxt;
  logic [HANDLE_W-1:0] ohandle_r, ohandle_nxt;

  logic [POS_W-1:0]    in_x, in_y, in_z;
  logic                in_acc, clearing, out_free, exec;
  logic [ADDR_W-1:0]   rd_addr, cur_addr, cell_wa;
  logic [SW-1:0]       free_rd_addr;
  logic [SIZE_W-1:0]   sx, sy, sz;
  logic                in_range, held, need_handle;
  kind_t               cell_kind_q, wr_kind;
  logic [SW-1:0]       cell_slot_q, new_slot, slot_wa;
  logic                kind_wr, cell_wr, slot_wr, free_wr;
  logic                cell_we, slot_we, free_we;
  logic [CELL_W-1:0]   cell_wd;
  cnt_upd_t            upd, upd_g;
  logic [COUNT_W-1:0]  solid_count, fluid_count, bc_count, undefined_count;

  assign in_x = in_tdata[IN_X_LSB +: POS_W];
  assign in_y = in_tdata[IN_Y_LSB +: POS_W];
  assign in_z = in_tdata[IN_Z_LSB +: POS_W];

  assign in_acc       = in_tvalid && in_tready;
  assign rd_addr      = {AW'(in_z), AW'(in_y), AW'(in_x)};
  assign cur_addr     = {AW'(pos_z_r), AW'(pos_y_r), AW'(pos_x_r)};
  assign free_rd_addr = SW'(free_top_r - SCW'(1));

  assign sx = (size_x_r > SIZE_CAP) ? SIZE_CAP : size_x_r;
  assign sy = (size_y_r > SIZE_CAP) ? SIZE_CAP : size_y_r;
  assign sz = (size_z_r > SIZE_CAP) ? SIZE_CAP : size_z_r;

  assign in_range = (SIZE_W'(pos_x_r) < sx) && (SIZE_W'(pos_y_r) < sy) &&
                    (SIZE_W'(pos_z_r) < sz);

  assign cell_kind_q = kind_t'(cell_rd_r[CELL_W-1 -: KIND_W]);
  assign cell_slot_q = cell_rd_r[SW-1:0];
  assign held        = (cell_kind_q == KIND_BC);

  always_comb begin
    kind_wr = 1'b0;
    wr_kind = KIND_UNDEF;
    case (op_r)
      OP_SOLID: begin
        kind_wr = 1'b1;
        wr_kind = KIND_SOLID;
      end
      OP_FLUID: begin
        kind_wr = 1'b1;
        wr_kind = KIND_FLUID;
      end
      OP_UNDEF: begin
        kind_wr = 1'b1;
        wr_kind = KIND_UNDEF;
      end
      OP_SET_KIND: begin
        kind_wr = (nk_r <= KIND_IFACE_FC);
        wr_kind = kind_t'(nk_r);
      end
      default: begin
        kind_wr = 1'b0;
        wr_kind = KIND_UNDEF;
      end
    endcase
  end

  assign need_handle = in_range && held && !kind_wr;
  assign out_free    = !out_valid_r || out_tready;
  assign exec        = out_free &&
                       ((state_r == ST_LOOK && !need_handle) || state_r == ST_HANDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (exec) state_nxt = ST_IDLE;
        else if (need_handle) state_nxt = ST_HANDLE;
      end
      ST_HANDLE: begin
        if (exec) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    clearing  = (state_r == ST_CLEAR);
  end

  always_comb begin
    status_nxt   = STATUS_DONE;
    okind_nxt    = cell_kind_q;
    oslot_nxt    = '0;
    ohandle_nxt  = '0;
    new_slot     = cell_slot_q;
    cell_wr      = 1'b0;
    cell_wd      = '0;
    slot_wr      = 1'b0;
    slot_wa      = cell_slot_q;
    free_wr      = 1'b0;
    free_top_nxt = free_top_r;
    slot_len_nxt = slot_len_r;
    upd          = '0;
    if (!in_range) begin
      status_nxt = STATUS_RANGE;
      okind_nxt  = KIND_UNDEF;
    end else if (op_r == OP_SET_BC) begin
      if (held && slot_rd_r == handle_r) begin
        status_nxt  = STATUS_SAME;
        oslot_nxt   = cell_slot_q;
        ohandle_nxt = slot_rd_r;
      end else if (!held && free_top_r == '0 && slot_len_r >= MAX_CNT) begin
        status_nxt = STATUS_FULL;
      end else begin
        if (held) begin
          new_slot = cell_slot_q;
        end else if (free_top_r != '0) begin
          new_slot     = free_rd_r;
          free_top_nxt = free_top_r - SCW'(1);
        end else begin
          new_slot     = slot_len_r[SW-1:0];
          slot_len_nxt = slot_len_r + SCW'(1);
        end
        slot_wr      = 1'b1;
        slot_wa      = new_slot;
        cell_wr      = 1'b1;
        cell_wd      = {KIND_BC, new_slot};
        upd.en       = 1'b1;
        upd.old_kind = cell_kind_q;
        upd.new_kind = KIND_BC;
        okind_nxt    = KIND_BC;
        oslot_nxt    = new_slot;
        ohandle_nxt  = handle_r;
      end
    end else if (kind_wr) begin
      if (held && free_top_r < MAX_CNT) begin
        free_wr      = 1'b1;
        free_top_nxt = free_top_r + SCW'(1);
      end
      cell_wr      = 1'b1;
      cell_wd      = {wr_kind, {SW{1'b0}}};
      upd.en       = 1'b1;
      upd.old_kind = cell_kind_q;
      upd.new_kind = wr_kind;
      okind_nxt    = wr_kind;
    end else if (held) begin
      oslot_nxt   = cell_slot_q;
      ohandle_nxt = slot_rd_r;
    end
  end

  assign cell_we  = clearing || (exec && cell_wr);
  assign cell_wa  = clearing ? clr_addr_r : cur_addr;
  assign slot_we  = exec && slot_wr;
  assign free_we  = exec && free_wr;

  always_comb begin
    upd_g    = upd;
    upd_g.en = exec && upd.en;
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= clearing ? '0 : cell_wd;
    if (in_acc) cell_rd_r <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= handle_r;
    if (state_r == ST_LOOK) slot_rd_r <= slot_mem[cell_slot_q];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_top_r[SW-1:0]] <= cell_slot_q;
    if (in_acc) free_rd_r <= free_mem[free_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      free_top_r  <= '0;
      slot_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (exec) begin
        free_top_r  <= free_top_nxt;
        slot_len_r  <= slot_len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RST;
      size_y_r <= SIZE_RST;
      size_z_r <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        CFG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_tuser;
      pos_x_r  <= in_x;
      pos_y_r  <= in_y;
      pos_z_r  <= in_z;
      handle_r <= in_tdata[IN_HANDLE_LSB +: HANDLE_W];
      nk_r     <= in_tdata[IN_KIND_LSB +: KIND_W];
    end
    if (exec) begin
      status_r  <= status_nxt;
      okind_r   <= okind_nxt;
      oslot_r   <= oslot_nxt;
      ohandle_r <= ohandle_nxt;
    end
  end

  ctm_stats #(
    .SIDE(SIDE)
  ) u_stats (
    .clk             (clk),
    .rst_n           (rst_n),
    .size_x          (sx),
    .size_y          (sy),
    .size_z          (sz),
    .upd             (upd_g),
    .solid_count     (solid_count),
    .fluid_count     (fluid_count),
    .bc_count        (bc_count),
    .undefined_count (undefined_count)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}},
                       SLOTS_OUT_W'(free_top_r),
                       SLOTS_OUT_W'(slot_len_r),
                       undefined_count,
                       bc_count,
                       fluid_count,
                       solid_count,
                       ohandle_r,
                       SLOT_OUT_W'(oslot_r),
                       okind_r};

endmodule

`default_nettype wire
